// ===== rtl/quaternion_to_euler_angles_top_defines.svh =====
// Assertion macros used by the checker file of the quaternion to Euler angle block.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QTE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/qte_pkg.sv =====
// Types, constants and helper functions of the quaternion to Euler angle block.
`default_nettype none

package qte_pkg;

   // Field widths and fixed-point formats.
   localparam int IN_W         = 16;
   localparam int PROD_W       = 2 * IN_W;
   localparam int PROD_FRAC    = 28;
   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 16;
   localparam int TAB_LEN      = 24;
   localparam int ANG_FRAC     = 24;
   localparam int OUT_FRAC     = 7;
   localparam int PITCH_W      = 15;
   localparam int ANGLE_W      = 16;

   // Q28 operand width: twice a sum of two products, plus sign.
   localparam int OPD_W  = PROD_W + 2;
   // Operand width after rounding to FRAC_BITS fraction bits (FRAC_BITS below PROD_FRAC).
   localparam int WORK_W = OPD_W - (PROD_FRAC - FRAC_BITS) + 1;
   // CORDIC datapath width with room for the gain and the pre-rotation.
   localparam int CORD_W = WORK_W + 3;
   localparam int ANG_W  = 34;
   localparam int CORD_N = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

   // Pitch sine and square root sizes.
   localparam int SIN_W    = PROD_FRAC + 2;
   localparam int SQ_IN_W  = 2 * PROD_FRAC + 2;
   localparam int SQ_STEPS = SQ_IN_W / 2;
   localparam int ROOT_W   = SQ_STEPS;
   localparam int SREM_W   = ROOT_W + 5;

   localparam logic signed [OPD_W-1:0] ONE_Q = OPD_W'(1) <<< PROD_FRAC;
   localparam logic signed [ANG_W-1:0] ANG_90 = 34'sd1509949440;
   localparam logic signed [ANGLE_W-1:0] PITCH_MAX = 16'sd11520;
   localparam logic signed [ANGLE_W-1:0] HALF_TURN_MAX = 16'sd23040;

   // atan(2^-i) in degrees with ANG_FRAC fraction bits.
   localparam logic signed [ANG_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
      34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
      34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
      34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
      34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
      34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
      34'sd917,       34'sd458,       34'sd229,       34'sd115
   };

   // One CORDIC lane: vector, angle so far, and the both-operands-zero mark.
   typedef struct packed {
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic signed [ANG_W-1:0]  ang;
      logic                     zero;
   } lane_type;

   // Operands carried alongside the square root.
   typedef struct packed {
      logic                     lock;
      logic signed [WORK_W-1:0] s_w;
      logic signed [WORK_W-1:0] hy;
      logic signed [WORK_W-1:0] hx;
      logic signed [WORK_W-1:0] by;
      logic signed [WORK_W-1:0] bx;
   } ctx_type;

   // One result item.
   typedef struct packed {
      logic                      lock;
      logic signed [ANGLE_W-1:0] bank;
      logic signed [ANGLE_W-1:0] heading;
      logic signed [PITCH_W-1:0] pitch;
   } result_type;

   // Q28 value to FRAC_BITS fraction bits, rounding to nearest with halves up.
   function automatic logic signed [WORK_W-1:0] to_work(input logic signed [OPD_W-1:0] v);
      logic signed [OPD_W:0] t;
      t = {v[OPD_W-1], v} + ((OPD_W+1)'(1) << (PROD_FRAC - FRAC_BITS - 1));
      return t[OPD_W:PROD_FRAC-FRAC_BITS];
   endfunction

   // Move the vector into the right half plane and mark the zero vector.
   function automatic lane_type prerot(input logic signed [WORK_W-1:0] yv,
                                       input logic signed [WORK_W-1:0] xv);
      lane_type r;
      logic signed [CORD_W-1:0] xe, ye;
      xe = CORD_W'(xv);
      ye = CORD_W'(yv);
      r.zero = (xv == '0) && (yv == '0);
      r.x = xe;
      r.y = ye;
      r.ang = '0;
      if (xv[WORK_W-1]) begin
         if (!yv[WORK_W-1]) begin
            r.x = ye;
            r.y = -xe;
            r.ang = ANG_90;
         end else begin
            r.x = -ye;
            r.y = xe;
            r.ang = -ANG_90;
         end
      end
      return r;
   endfunction

   // One vectoring iteration; shifts floor toward minus infinity.
   function automatic lane_type cordic_step(input lane_type a, input int unsigned i);
      lane_type r;
      logic signed [CORD_W-1:0] dx, dy;
      dx = a.x >>> i;
      dy = a.y >>> i;
      r = a;
      if (!a.y[CORD_W-1]) begin
         r.x = a.x + dy;
         r.y = a.y - dx;
         r.ang = a.ang + ATAN_TAB[i];
      end else begin
         r.x = a.x - dy;
         r.y = a.y + dx;
         r.ang = a.ang - ATAN_TAB[i];
      end
      return r;
   endfunction

   // Angle to Q9.7 degrees, rounded half up, then saturated to +-lim.
   function automatic logic signed [ANGLE_W-1:0] deg_out(input logic signed [ANG_W-1:0] ang,
                                                         input logic signed [ANGLE_W-1:0] lim);
      logic signed [ANG_W:0] t;
      logic signed [ANG_W-ANG_FRAC+OUT_FRAC:0] v;
      t = {ang[ANG_W-1], ang} + ((ANG_W+1)'(1) << (ANG_FRAC - OUT_FRAC - 1));
      v = t[ANG_W:ANG_FRAC-OUT_FRAC];
      if (v > lim) begin
         return lim;
      end else if (v < -lim) begin
         return -lim;
      end
      return v[ANGLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/qte_pipe.sv =====
// Pipelined datapath: products, pitch sine, square root, three CORDIC lanes, rounding.
`default_nettype none

module qte_pipe (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic signed [qte_pkg::IN_W-1:0] quat_w,
   input  wire logic signed [qte_pkg::IN_W-1:0] quat_x,
   input  wire logic signed [qte_pkg::IN_W-1:0] quat_y,
   input  wire logic signed [qte_pkg::IN_W-1:0] quat_z,
   output logic                                 out_valid,
   output qte_pkg::result_type                  out_result
);

   localparam int LAT = 4 + qte_pkg::SQ_STEPS + 2 + qte_pkg::CORD_N + 1;
   localparam int PW  = qte_pkg::PROD_W;
   localparam int OW  = qte_pkg::OPD_W;
   localparam int NW  = qte_pkg::SQ_IN_W;
   localparam int RW  = qte_pkg::ROOT_W;
   localparam int MW  = qte_pkg::SREM_W;
   localparam int SQN = qte_pkg::SQ_STEPS;
   localparam int CN  = qte_pkg::CORD_N;

   // Valid bits travel with the items.
   logic [LAT-1:0] vld_ff, vld_in;

   assign vld_in = {vld_ff[LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: the nine products of the quaternion components that the angles use.
   logic signed [PW-1:0] wx_ff, yz_ff, wy_ff, xz_ff, yy_ff, zz_ff, xx_ff, xy_ff, wz_ff;
   logic signed [PW-1:0] wx_in, yz_in, wy_in, xz_in, yy_in, zz_in, xx_in, xy_in, wz_in;

   always_comb begin
      wx_in = quat_w * quat_x;
      yz_in = quat_y * quat_z;
      wy_in = quat_w * quat_y;
      xz_in = quat_x * quat_z;
      yy_in = quat_y * quat_y;
      zz_in = quat_z * quat_z;
      xx_in = quat_x * quat_x;
      xy_in = quat_x * quat_y;
      wz_in = quat_w * quat_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= wx_in;
         yz_ff <= yz_in;
         wy_ff <= wy_in;
         xz_ff <= xz_in;
         yy_ff <= yy_in;
         zz_ff <= zz_in;
         xx_ff <= xx_in;
         xy_ff <= xy_in;
         wz_ff <= wz_in;
      end
   end

   // Stage 2: clamped pitch sine, lock flag and the Q28 atan2 operands.
   logic signed [qte_pkg::SIN_W-1:0] s2_ff, s2_in;
   logic                             lock2_ff, lock2_in;
   logic signed [OW-1:0]             hy2_ff, hx2_ff, by2_ff, bx2_ff;
   logic signed [OW-1:0]             hy2_in, hx2_in, by2_in, bx2_in;

   always_comb begin
      logic signed [OW-1:0] s_full;
      s_full = (OW'(wx_ff) - OW'(yz_ff)) <<< 1;
      lock2_in = 1'b1;
      if (s_full >= qte_pkg::ONE_Q) begin
         s2_in = qte_pkg::SIN_W'(qte_pkg::ONE_Q);
      end else if (s_full <= -qte_pkg::ONE_Q) begin
         s2_in = qte_pkg::SIN_W'(-qte_pkg::ONE_Q);
      end else begin
         s2_in = s_full[qte_pkg::SIN_W-1:0];
         lock2_in = 1'b0;
      end
      // Gimbal lock takes the alternative heading pair.
      if (lock2_in) begin
         hy2_in = (OW'(wy_ff) - OW'(xz_ff)) <<< 1;
         hx2_in = qte_pkg::ONE_Q - ((OW'(yy_ff) + OW'(zz_ff)) <<< 1);
      end else begin
         hy2_in = (OW'(xz_ff) + OW'(wy_ff)) <<< 1;
         hx2_in = qte_pkg::ONE_Q - ((OW'(xx_ff) + OW'(yy_ff)) <<< 1);
      end
      by2_in = (OW'(xy_ff) + OW'(wz_ff)) <<< 1;
      bx2_in = qte_pkg::ONE_Q - ((OW'(zz_ff) + OW'(xx_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff    <= s2_in;
         lock2_ff <= lock2_in;
         hy2_ff   <= hy2_in;
         hx2_ff   <= hx2_in;
         by2_ff   <= by2_in;
         bx2_ff   <= bx2_in;
      end
   end

   // Stage 3: square of the sine and rounding of the operands.
   logic [NW-1:0]    sq3_ff, sq3_in;
   qte_pkg::ctx_type ctx3_ff, ctx3_in;

   always_comb begin
      logic signed [2*qte_pkg::SIN_W-1:0] p;
      p = s2_ff * s2_ff;
      sq3_in = p[NW-1:0];
      ctx3_in.lock = lock2_ff;
      ctx3_in.s_w  = qte_pkg::to_work(OW'(s2_ff));
      ctx3_in.hy   = qte_pkg::to_work(hy2_ff);
      ctx3_in.hx   = qte_pkg::to_work(hx2_ff);
      ctx3_in.by   = qte_pkg::to_work(by2_ff);
      ctx3_in.bx   = qte_pkg::to_work(bx2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq3_ff  <= sq3_in;
         ctx3_ff <= ctx3_in;
      end
   end

   // Stage 4 and the square root: one root bit per stage, restoring form.
   logic [NW-1:0]    n_ff [0:SQN];
   logic [NW-1:0]    n_in [0:SQN];
   logic [MW-1:0]    r_ff [0:SQN];
   logic [MW-1:0]    r_in [0:SQN];
   logic [RW-1:0]    q_ff [0:SQN];
   logic [RW-1:0]    q_in [0:SQN];
   qte_pkg::ctx_type sctx_ff [0:SQN];
   qte_pkg::ctx_type sctx_in [0:SQN];

   // Stage 4 loads one minus the squared sine in Q56.
   always_comb begin
      n_in[0]    = (NW'(1) << (2 * qte_pkg::PROD_FRAC)) - sq3_ff;
      r_in[0]    = '0;
      q_in[0]    = '0;
      sctx_in[0] = ctx3_ff;
   end

   for (genvar k = 0; k < SQN; k++) begin : g_sqrt
      always_comb begin
         logic [MW-1:0] r_sh, t;
         r_sh = {r_ff[k][MW-3:0], n_ff[k][NW-1 -: 2]};
         t = {{(MW-RW-2){1'b0}}, q_ff[k], 2'b01};
         if (r_sh >= t) begin
            r_in[k+1] = r_sh - t;
            q_in[k+1] = {q_ff[k][RW-2:0], 1'b1};
         end else begin
            r_in[k+1] = r_sh;
            q_in[k+1] = {q_ff[k][RW-2:0], 1'b0};
         end
         n_in[k+1]    = {n_ff[k][NW-3:0], 2'b00};
         sctx_in[k+1] = sctx_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= SQN; k++) begin
            n_ff[k]    <= n_in[k];
            r_ff[k]    <= r_in[k];
            q_ff[k]    <= q_in[k];
            sctx_ff[k] <= sctx_in[k];
         end
      end
   end

   // Cosine of pitch rounded to the working format.
   logic signed [qte_pkg::WORK_W-1:0] c_ff, c_in;
   qte_pkg::ctx_type                  cctx_ff, cctx_in;

   assign c_in    = qte_pkg::to_work(OW'(q_ff[SQN]));
   assign cctx_in = sctx_ff[SQN];

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff    <= c_in;
         cctx_ff <= cctx_in;
      end
   end

   // Pre-rotation and CORDIC iterations for pitch, heading and bank lanes.
   qte_pkg::lane_type pl_ff [0:CN];
   qte_pkg::lane_type pl_in [0:CN];
   qte_pkg::lane_type hl_ff [0:CN];
   qte_pkg::lane_type hl_in [0:CN];
   qte_pkg::lane_type bl_ff [0:CN];
   qte_pkg::lane_type bl_in [0:CN];
   logic              lk_ff [0:CN];
   logic              lk_in [0:CN];
   logic              sn_ff [0:CN];
   logic              sn_in [0:CN];

   always_comb begin
      pl_in[0] = qte_pkg::prerot(cctx_ff.s_w, c_ff);
      hl_in[0] = qte_pkg::prerot(cctx_ff.hy, cctx_ff.hx);
      bl_in[0] = qte_pkg::prerot(cctx_ff.by, cctx_ff.bx);
      lk_in[0] = cctx_ff.lock;
      sn_in[0] = cctx_ff.s_w[qte_pkg::WORK_W-1];
   end

   for (genvar i = 0; i < CN; i++) begin : g_cordic
      always_comb begin
         pl_in[i+1] = qte_pkg::cordic_step(pl_ff[i], i);
         hl_in[i+1] = qte_pkg::cordic_step(hl_ff[i], i);
         bl_in[i+1] = qte_pkg::cordic_step(bl_ff[i], i);
         lk_in[i+1] = lk_ff[i];
         sn_in[i+1] = sn_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= CN; i++) begin
            pl_ff[i] <= pl_in[i];
            hl_ff[i] <= hl_in[i];
            bl_ff[i] <= bl_in[i];
            lk_ff[i] <= lk_in[i];
            sn_ff[i] <= sn_in[i];
         end
      end
   end

   // Output stage: rounding, saturation and the gimbal lock overrides.
   qte_pkg::result_type res_ff, res_in;

   always_comb begin
      logic signed [qte_pkg::ANG_W-1:0]   pa, ha, ba;
      logic signed [qte_pkg::ANGLE_W-1:0] pd;
      pa = pl_ff[CN].zero ? '0 : pl_ff[CN].ang;
      ha = hl_ff[CN].zero ? '0 : hl_ff[CN].ang;
      ba = bl_ff[CN].zero ? '0 : bl_ff[CN].ang;
      if (lk_ff[CN]) begin
         pd = sn_ff[CN] ? -qte_pkg::PITCH_MAX : qte_pkg::PITCH_MAX;
         res_in.bank = '0;
      end else begin
         pd = qte_pkg::deg_out(pa, qte_pkg::PITCH_MAX);
         res_in.bank = qte_pkg::deg_out(ba, qte_pkg::HALF_TURN_MAX);
      end
      res_in.pitch   = pd[qte_pkg::PITCH_W-1:0];
      res_in.heading = qte_pkg::deg_out(ha, qte_pkg::HALF_TURN_MAX);
      res_in.lock    = lk_ff[CN];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid  = vld_ff[LAT-1];
   assign out_result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/quaternion_to_euler_angles_top.sv =====
// Top level of the quaternion to heading, pitch and bank converter with its stream ports.
`default_nettype none

// Converts a Q1.14 quaternion into pitch, heading and bank in Q9.7 degrees and flags
// gimbal lock. One item enters per clock while the skid register is empty; each item
// passes the product stages, the 29-stage square root for the pitch cosine, the 16
// CORDIC stages and the rounding and output stages. When the result side stalls, one
// more result is caught in a skid register before the input side stops taking items.

module quaternion_to_euler_angles_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // pitch_deg, heading_deg, bank_deg, zero pad
   output logic [0:0]       rsp_tuser    // gimbal_lock
);

   logic                pipe_en;
   logic                pipe_vld;
   qte_pkg::result_type pipe_res;
   logic                arrive;
   logic                rsp_free;

   logic                rsp_vld_ff, rsp_vld_in;
   qte_pkg::result_type rsp_res_ff, rsp_res_in;
   logic                skid_vld_ff, skid_vld_in;
   qte_pkg::result_type skid_res_ff, skid_res_in;

   // The pipeline moves whenever the skid register is empty.
   assign pipe_en    = !skid_vld_ff;
   assign req_tready = pipe_en;

   qte_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_valid   (req_tvalid),
      .quat_w     (req_tdata[15:0]),
      .quat_x     (req_tdata[31:16]),
      .quat_y     (req_tdata[47:32]),
      .quat_z     (req_tdata[63:48]),
      .out_valid  (pipe_vld),
      .out_result (pipe_res)
   );

   // Output register with a skid stage behind it.
   always_comb begin
      arrive      = pipe_en && pipe_vld;
      rsp_free    = !rsp_vld_ff || rsp_tready;
      rsp_vld_in  = rsp_vld_ff;
      rsp_res_in  = rsp_res_ff;
      skid_vld_in = skid_vld_ff;
      skid_res_in = skid_res_ff;
      if (rsp_free) begin
         rsp_vld_in  = skid_vld_ff || arrive;
         rsp_res_in  = skid_vld_ff ? skid_res_ff : pipe_res;
         skid_vld_in = 1'b0;
      end else if (arrive) begin
         skid_vld_in = 1'b1;
         skid_res_in = pipe_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff  <= rsp_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_res_ff.bank, rsp_res_ff.heading, rsp_res_ff.pitch};
   assign rsp_tuser  = rsp_res_ff.lock;

endmodule

`default_nettype wire

// ===== rtl/qte_checker.sv =====
// Port-level checks of the quaternion to Euler angle block, bound to its top level.
`default_nettype none

`include "quaternion_to_euler_angles_top_defines.svh"

module qte_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // A stalled result stays put.
   `QTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // Bank is zero under gimbal lock.
   `QTE_ASSERT_NOW(a_lock_bank, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[46:31] == 16'd0, "bank not zero in gimbal lock")

   // Pitch sits exactly at a pole under gimbal lock.
   `QTE_ASSERT_NOW(a_lock_pitch, clock, reset, rsp_tvalid && rsp_tuser[0], $signed(rsp_tdata[14:0]) == 15'sd11520 || $signed(rsp_tdata[14:0]) == -15'sd11520, "pitch not at a pole in gimbal lock")

   // Pitch never leaves plus or minus ninety degrees.
   `QTE_ASSERT_NOW(a_pitch_range, clock, reset, rsp_tvalid, $signed(rsp_tdata[14:0]) <= 15'sd11520 && $signed(rsp_tdata[14:0]) >= -15'sd11520, "pitch out of range")

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== test/tb_quaternion_to_euler_angles_top.sv =====
// Testbench of the quaternion to Euler angle converter: random and directed items, own predictor.
`default_nettype none

module tb_quaternion_to_euler_angles_top;

   localparam int NUM_RANDOM = 1400;
   localparam int LATENCY    = 52;
   localparam longint CYCLE_LIMIT = 400000;

   // Predicted angles of one quaternion.
   typedef struct {
      logic signed [14:0] pitch;
      logic signed [15:0] heading;
      logic signed [15:0] bank;
      logic               lock;
   } angles_type;

   // Degrees with 24 fraction bits; atan(2^-i) per step.
   localparam longint ATAN_DEG [0:23] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // quat_w, quat_x, quat_y, quat_z
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // pitch_deg, heading_deg, bank_deg, zero pad
   logic [0:0]  rsp_tuser;   // gimbal_lock

   logic [63:0] quat_queue[$];
   angles_type  angle_queue[$];
   int          errors = 0;
   int          sent;
   int          checked;
   int          locks_seen;
   longint      cycle_count;
   int          send_wait;
   int          recv_wait;
   bit          stimulus_done;
   bit          hold_off;

   quaternion_to_euler_angles_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Floor shift and round-half-up shift of a signed value.
   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_sh(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint isqrt(longint n);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   // Vectoring arctangent in degrees, 24 fraction bits.
   function automatic longint vector_angle(longint yv, longint xv);
      longint ang, t, dx, dy;
      ang = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         t = xv;
         if (yv >= 0) begin
            xv = yv; yv = -t; ang = 64'sd90 <<< 24;
         end else begin
            xv = -yv; yv = t; ang = -(64'sd90 <<< 24);
         end
      end
      for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
         dx = floor_sh(xv, i);
         dy = floor_sh(yv, i);
         if (yv >= 0) begin
            xv += dy; yv -= dx; ang += ATAN_DEG[i];
         end else begin
            xv -= dy; yv += dx; ang -= ATAN_DEG[i];
         end
      end
      return ang;
   endfunction

   function automatic longint angle_deg(longint yq, longint xq, longint lim);
      longint v;
      v = round_sh(vector_angle(round_sh(yq, 28 - qte_pkg::FRAC_BITS),
                                round_sh(xq, 28 - qte_pkg::FRAC_BITS)),
                   17);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic angles_type predict_angles(logic [63:0] q);
      angles_type r;
      longint w, x, y, z, s, one, c;
      one = 64'sd1 <<< 28;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      s = 2 * (w * x - y * z);
      if (s > one) s = one;
      if (s < -one) s = -one;
      r.lock = (s == one) || (s == -one);
      if (r.lock) begin
         r.pitch = (s > 0) ? 15'sd11520 : -15'sd11520;
         r.heading = 16'(angle_deg(2 * (w * y - x * z), one - 2 * (y * y + z * z), 23040));
         r.bank = '0;
      end else begin
         c = isqrt((64'sd1 <<< 56) - s * s);
         r.pitch = 15'(angle_deg(s, c, 11520));
         r.heading = 16'(angle_deg(2 * (z * x + w * y), one - 2 * (x * x + y * y), 23040));
         r.bank = 16'(angle_deg(2 * (x * y + w * z), one - 2 * (z * z + x * x), 23040));
      end
      return r;
   endfunction

   function automatic logic [15:0] rand_comp();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 16'($urandom_range(0, 65535));
      if (k == 1) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // Mostly a roughly unit quaternion from a random point, else raw random components.
   function automatic logic [63:0] rand_quat();
      int k;
      real a, b, c, d, n;
      k = $urandom_range(0, 9);
      if (k < 2)
         return {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      a = $itor($signed($urandom_range(0, 2000)) - 1000);
      b = $itor($signed($urandom_range(0, 2000)) - 1000);
      c = $itor($signed($urandom_range(0, 2000)) - 1000);
      d = $itor($signed($urandom_range(0, 2000)) - 1000);
      if (k == 2) begin
         // Near gimbal lock: w close to +-x, y close to -+z.
         b = $urandom_range(0, 1) ? a : -a;
         d = (b == a) ? -c : c;
         b = b + $itor($signed($urandom_range(0, 4)) - 2);
      end
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) return 64'd0;
      return {16'($rtoi(d / n * 16384.0)), 16'($rtoi(c / n * 16384.0)),
              16'($rtoi(b / n * 16384.0)), 16'($rtoi(a / n * 16384.0))};
   endfunction

   // Fill the queue: directed corners first, then random quaternions.
   initial begin
      logic [15:0] h;
      h = 16'sd8192;
      quat_queue.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
      quat_queue.push_back({16'sd0, 16'sd0, 16'sd0, -16'sd16384});
      quat_queue.push_back(64'd0);
      quat_queue.push_back({4{16'h7fff}});
      quat_queue.push_back({4{16'h8000}});
      quat_queue.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
      quat_queue.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0});
      quat_queue.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd0});
      quat_queue.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
      quat_queue.push_back({16'sd0, -16'sd16384, 16'sd0, 16'sd0});
      quat_queue.push_back({16'sd0, 16'sd0, 16'sd11585, 16'sd11585});
      quat_queue.push_back({16'sd0, 16'sd0, -16'sd11585, 16'sd11585});
      quat_queue.push_back({16'sd0, 16'sd0, 16'sd11586, 16'sd11586});
      quat_queue.push_back({-h, h, -h, h});
      quat_queue.push_back({h, -h, h, h});
      quat_queue.push_back({-h, -h, h, -h});
      quat_queue.push_back({h, h, h, h});
      quat_queue.push_back({16'sd0, 16'sd11585, 16'sd0, 16'sd11585});
      quat_queue.push_back({16'sd0, 16'sd11585, 16'sd11585, 16'sd0});
      quat_queue.push_back({16'sd100, 16'sd0, 16'sd0, 16'sd0});
      for (int i = 0; i < NUM_RANDOM; i++) quat_queue.push_back(rand_quat());
   end

   // Driver: takes items from the queue with random gaps and one drain pause.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_wait <= 0;
         sent <= 0;
         stimulus_done <= 1'b0;
         hold_off <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            angle_queue.push_back(predict_angles(req_tdata));
            sent <= sent + 1;
         end
         if (sent == 700 && req_tvalid && !hold_off) begin
            hold_off <= 1'b1;
            req_tvalid <= 1'b0;
         end else if (hold_off && sent == 701 && angle_queue.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_tvalid <= 1'b0;
         end else if (quat_queue.size() != 0) begin
            req_tdata <= quat_queue.pop_front();
            req_tvalid <= 1'b1;
            send_wait <= ((sent > 900 && sent < 1100) || $urandom_range(0, 3) == 0) ?
                         0 : $urandom_range(0, 6);
         end else begin
            req_tvalid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // Monitor: compares each result with the oldest prediction, stalls at random.
   always @(posedge clock) begin
      angles_type e;
      logic signed [14:0] p;
      logic signed [15:0] hd, bk;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait <= 0;
         checked <= 0;
         locks_seen <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            p = rsp_tdata[14:0];
            hd = rsp_tdata[30:15];
            bk = rsp_tdata[46:31];
            checked <= checked + 1;
            if (angle_queue.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               e = angle_queue.pop_front();
               if (e.lock) locks_seen <= locks_seen + 1;
               if (p !== e.pitch) begin
                  $error("pitch_deg expected %0d actual %0d", e.pitch, p);
                  errors++;
               end
               if (hd !== e.heading) begin
                  $error("heading_deg expected %0d actual %0d", e.heading, hd);
                  errors++;
               end
               if (bk !== e.bank) begin
                  $error("bank_deg expected %0d actual %0d", e.bank, bk);
                  errors++;
               end
               if (rsp_tuser[0] !== e.lock) begin
                  $error("gimbal_lock expected %0d actual %0d", e.lock, rsp_tuser[0]);
                  errors++;
               end
            end
         end
         if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               recv_wait <= (sent > 900 && sent < 1100) ? 0 : $urandom_range(0, 6);
         end
      end
   end

   // Reset, timeout and the final verdict.
   initial begin
      cycle_count = 0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && angle_queue.size() == 0) && cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
      end else begin
         repeat (LATENCY + 10) @(posedge clock);
         $display("Covered %0d quaternions, %0d results checked, %0d in gimbal lock.",
                  sent, checked, locks_seen);
         if (errors == 0 && angle_queue.size() == 0) begin
            $display("tb: success");
         end else begin
            $display("tb: failure");
         end
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/qte_pkg.sv
rtl/qte_pipe.sv
rtl/quaternion_to_euler_angles_top.sv
rtl/qte_checker.sv
test/tb_quaternion_to_euler_angles_top.sv
